### hdl/cdws_pkg.sv
// ----------------------------------------------------------------------------
// cdws_pkg: shared types and constants for the countdown wake scheduler
// Holds the day-number width, configuration register indexes and the
// month offset table used by the civil-date day-number logic.
// ----------------------------------------------------------------------------
package cdws_pkg;

	// Day numbers span roughly -365 .. 6.0e6, so 24 signed bits hold them
	// and the difference of two of them.
	localparam int DN_W = 24;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_YEAR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MONTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_IVAL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DAILY_SLEEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_SLEEP  = 3'd6;

	localparam int CFG_DATA_W = 18;

	// Reciprocal of 100 in 2^-19 units; exact for every 14-bit year.
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;

	// Days before the first of the month in a March-based year, indexed by
	// the raw month code. January and February (and month zero) belong to
	// the end of the previous year.
	function automatic logic [8:0] month_offset(input logic [3:0] mon);
		logic [8:0] off;
		unique case (mon)
			4'd0:  off = 9'd275;
			4'd1:  off = 9'd306;
			4'd2:  off = 9'd337;
			4'd3:  off = 9'd0;
			4'd4:  off = 9'd31;
			4'd5:  off = 9'd61;
			4'd6:  off = 9'd92;
			4'd7:  off = 9'd122;
			4'd8:  off = 9'd153;
			4'd9:  off = 9'd184;
			4'd10: off = 9'd214;
			4'd11: off = 9'd245;
			4'd12: off = 9'd275;
			4'd13: off = 9'd306;
			4'd14: off = 9'd337;
			4'd15: off = 9'd367;
		endcase
		return off;
	endfunction

endpackage

### hdl/cdws_day_number.sv
// ----------------------------------------------------------------------------
// cdws_day_number: civil date to day number
// Combinational day count of a date with January and February moved to the
// end of the previous year. Divisions by 4, 100 and 400 truncate toward zero.
// ----------------------------------------------------------------------------
module cdws_day_number (
	input  logic [13:0]                 year,
	input  logic [3:0]                  month,
	input  logic [4:0]                  day,
	output logic signed [cdws_pkg::DN_W-1:0] day_num
);
	import cdws_pkg::*;

	logic signed [14:0]     y_adj;
	logic [13:0]            y_pos;
	logic [26:0]            prod100;
	logic [7:0]             q100;
	logic [11:0]            q4;
	logic [5:0]             q400;
	logic signed [DN_W-1:0] y_ext;
	logic signed [DN_W-1:0] y365;

	assign y_adj = (month <= 4'd2) ? ($signed({1'b0, year}) - 15'sd1)
	                               : $signed({1'b0, year});

	// The only negative adjusted year is -1, whose quotients all truncate to 0.
	assign y_pos   = y_adj[14] ? 14'd0 : y_adj[13:0];
	assign prod100 = 27'(y_pos) * 27'(DIV100_MUL);
	assign q100    = prod100[DIV100_SHIFT +: 8];
	assign q4      = y_pos[13:2];
	assign q400    = q100[7:2];

	assign y_ext = {{(DN_W-15){y_adj[14]}}, y_adj};
	assign y365  = y_ext * 24'sd365;

	assign day_num = y365
	               + $signed(DN_W'(q4))
	               - $signed(DN_W'(q100))
	               + $signed(DN_W'(q400))
	               + $signed(DN_W'(month_offset(month)))
	               + $signed(DN_W'(day));

endmodule

### hdl/countdown_wake_sync_scheduler_top.sv
// ----------------------------------------------------------------------------
// countdown_wake_sync_scheduler_top: countdown wake-up and time sync scheduler
// Input is registered in stage one, today's day number in stage two and the
// result in stage three. Throughput: one transaction per cycle while the output
// is accepted; the three register stages stall as one elastic pipeline, so
// ready drops only when every stage holds an item. The count and state update
// settle in stage three. Reset returns the state to "no baseline" and loads
// the configuration registers with their reset values; no clearing pass.
// ----------------------------------------------------------------------------
module countdown_wake_sync_scheduler_top (
	input  logic                                clk,
	input  logic                                arst_n,

	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cdws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cdws_pkg::CFG_DATA_W-1:0]     cfg_data,

	// Wake-up input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  backup_days,
	input  logic                                sync_ok,
	input  logic                                clock_valid,
	input  logic [13:0]                         now_year,
	input  logic [3:0]                          now_month,
	input  logic [4:0]                          now_day,

	// Result channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  days_left,
	output logic                                sync_attempted,
	output logic                                display_refresh,
	output logic                                show_sync_failed,
	output logic                                save_backup,
	output logic [17:0]                         sleep_seconds
);
	import cdws_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls; writes to an index
	// beyond the register list are dropped.
	// ------------------------------------------------------------------
	logic [13:0] target_year_q;
	logic [3:0]  target_month_q;
	logic [4:0]  target_day_q;
	logic [7:0]  sync_ival_q;
	logic [7:0]  retry_limit_q;
	logic [17:0] daily_sleep_q;
	logic [17:0] retry_sleep_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_year_q  <= 14'd2030;
			target_month_q <= 4'd1;
			target_day_q   <= 5'd1;
			sync_ival_q    <= 8'd7;
			retry_limit_q  <= 8'd6;
			daily_sleep_q  <= 18'd86400;
			retry_sleep_q  <= 18'd14400;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TARGET_YEAR:  target_year_q  <= cfg_data[13:0];
				CFG_TARGET_MONTH: target_month_q <= cfg_data[3:0];
				CFG_TARGET_DAY:   target_day_q   <= cfg_data[4:0];
				CFG_SYNC_IVAL:    sync_ival_q    <= cfg_data[7:0];
				CFG_RETRY_LIMIT:  retry_limit_q  <= cfg_data[7:0];
				CFG_DAILY_SLEEP:  daily_sleep_q  <= cfg_data[17:0];
				CFG_RETRY_SLEEP:  retry_sleep_q  <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// The target day number depends on configuration alone, so it is kept in a
	// register of its own. It settles in the cycle after a write, which is before
	// any item taken at or after that write reaches the final stage.
	logic signed [DN_W-1:0] target_dn;
	logic signed [DN_W-1:0] target_dn_q;

	cdws_day_number u_target_dn (
		.year    (target_year_q),
		.month   (target_month_q),
		.day     (target_day_q),
		.day_num (target_dn)
	);

	always_ff @(posedge clk) begin
		target_dn_q <= target_dn;
	end

	// ------------------------------------------------------------------
	// Elastic pipeline control. Each stage advances when the next one is
	// empty or moving, so a result waiting at the output does not stop
	// new transactions from being taken until all stages are full.
	// ------------------------------------------------------------------
	logic s1_v_q, s2_v_q, s3_v_q;
	logic s1_rdy, s2_rdy, s3_rdy;

	assign s3_rdy   = !s3_v_q || out_ready;
	assign s2_rdy   = !s2_v_q || s3_rdy;
	assign s1_rdy   = !s1_v_q || s2_rdy;
	assign in_ready = s1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
		end else begin
			if (s1_rdy) begin
				s1_v_q <= in_valid;
			end
			if (s2_rdy) begin
				s2_v_q <= s1_v_q;
			end
			if (s3_rdy) begin
				s3_v_q <= s2_v_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage one: input register.
	// ------------------------------------------------------------------
	logic signed [15:0] backup_s1;
	logic               ok_s1;
	logic               cv_s1;
	logic [13:0]        year_s1;
	logic [3:0]         month_s1;
	logic [4:0]         day_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			backup_s1 <= backup_days;
			ok_s1     <= sync_ok;
			cv_s1     <= clock_valid;
			year_s1   <= now_year;
			month_s1  <= now_month;
			day_s1    <= now_day;
		end
	end

	// ------------------------------------------------------------------
	// Stage two: today's day number.
	// ------------------------------------------------------------------
	logic signed [DN_W-1:0] today_dn;
	logic signed [DN_W-1:0] today_s2;
	logic signed [15:0]     backup_s2;
	logic                   ok_s2;
	logic                   cv_s2;

	cdws_day_number u_today_dn (
		.year    (year_s1),
		.month   (month_s1),
		.day     (day_s1),
		.day_num (today_dn)
	);

	always_ff @(posedge clk) begin
		if (s1_v_q && s2_rdy) begin
			today_s2  <= today_dn;
			backup_s2 <= backup_s1;
			ok_s2     <= ok_s1;
			cv_s2     <= cv_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage three: count from the clock, mode decision and state update.
	// The scheduler state changes in the same edge that loads the result,
	// so the next item in stage two always sees the updated state.
	// ------------------------------------------------------------------
	logic signed [15:0] days_rem_q;
	logic [7:0]         since_sync_q;
	logic               retry_mode_q;
	logic [7:0]         retry_cnt_q;

	logic signed [DN_W-1:0] diff;
	logic [14:0]            clk_cnt;

	assign diff = target_dn_q - today_s2;

	// A target in the past gives zero; far targets saturate at 32767.
	always_comb begin
		if (diff[DN_W-1]) begin
			clk_cnt = 15'd0;
		end else if (diff > $signed(DN_W'(16'h7FFF))) begin
			clk_cnt = 15'h7FFF;
		end else begin
			clk_cnt = diff[14:0];
		end
	end

	logic signed [15:0] dr_n;
	logic [7:0]         since_n;
	logic               retry_n;
	logic [7:0]         rcnt_n;
	logic               attempted_n;
	logic               refresh_n;
	logic               failed_n;
	logic               save_n;
	logic [17:0]        sleep_n;

	always_comb begin
		logic signed [15:0] cnt;
		logic [7:0]         rcnt_inc;
		logic [7:0]         since_inc;

		cnt         = $signed({1'b0, clk_cnt});
		dr_n        = days_rem_q[15] ? backup_s2 : days_rem_q;
		since_n     = since_sync_q;
		retry_n     = retry_mode_q;
		rcnt_n      = retry_cnt_q;
		attempted_n = 1'b0;
		refresh_n   = 1'b0;
		failed_n    = 1'b0;
		save_n      = 1'b0;
		sleep_n     = daily_sleep_q;
		rcnt_inc    = (retry_cnt_q == 8'hFF) ? retry_cnt_q : retry_cnt_q + 8'd1;
		since_inc   = (since_sync_q == 8'hFF) ? since_sync_q : since_sync_q + 8'd1;

		priority if (retry_mode_q) begin
			// Retry wake: a good sync or the limit ends retrying; else count the miss.
			attempted_n = 1'b1;
			if (ok_s2) begin
				if (cv_s2) begin
					dr_n = cnt;
				end
				retry_n   = 1'b0;
				rcnt_n    = 8'd0;
				since_n   = 8'd1;
				save_n    = 1'b1;
				refresh_n = 1'b1;
			end else if (rcnt_inc >= retry_limit_q) begin
				retry_n = 1'b0;
				rcnt_n  = 8'd0;
				since_n = since_inc;
			end else begin
				rcnt_n  = rcnt_inc;
				sleep_n = retry_sleep_q;
			end
		end else if (dr_n[15]) begin
			// No baseline: a good sync sets it, zero if clock unreadable; a miss retries.
			attempted_n = 1'b1;
			if (ok_s2) begin
				dr_n      = cv_s2 ? cnt : 16'sd0;
				since_n   = 8'd1;
				save_n    = 1'b1;
				refresh_n = 1'b1;
			end else begin
				retry_n = 1'b1;
				rcnt_n  = 8'd1;
				sleep_n = retry_sleep_q;
			end
		end else begin
			// Daily wake: step the count down and resync when the interval is due.
			if (dr_n != 16'sd0) begin
				dr_n = dr_n - 16'sd1;
			end
			since_n = since_inc;
			if (since_inc >= sync_ival_q) begin
				attempted_n = 1'b1;
				if (ok_s2) begin
					if (cv_s2) begin
						dr_n = cnt;
					end
					since_n = 8'd1;
				end else begin
					failed_n = 1'b1;
					retry_n  = 1'b1;
					rcnt_n   = 8'd0;
					sleep_n  = retry_sleep_q;
				end
			end
			save_n    = 1'b1;
			refresh_n = 1'b1;
		end
	end

	logic s3_load;
	assign s3_load = s2_v_q && s3_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_rem_q   <= -16'sd1;
			since_sync_q <= 8'd0;
			retry_mode_q <= 1'b0;
			retry_cnt_q  <= 8'd0;
		end else if (s3_load) begin
			days_rem_q   <= dr_n;
			since_sync_q <= since_n;
			retry_mode_q <= retry_n;
			retry_cnt_q  <= rcnt_n;
		end
	end

	logic signed [15:0] days_left_s3;
	logic               attempted_s3;
	logic               refresh_s3;
	logic               failed_s3;
	logic               save_s3;
	logic [17:0]        sleep_s3;

	always_ff @(posedge clk) begin
		if (s3_load) begin
			days_left_s3 <= dr_n;
			attempted_s3 <= attempted_n;
			refresh_s3   <= refresh_n;
			failed_s3    <= failed_n;
			save_s3      <= save_n;
			sleep_s3     <= sleep_n;
		end
	end

	assign out_valid        = s3_v_q;
	assign days_left        = days_left_s3;
	assign sync_attempted   = attempted_s3;
	assign display_refresh  = refresh_s3;
	assign show_sync_failed = failed_s3;
	assign save_backup      = save_s3;
	assign sleep_seconds    = sleep_s3;

endmodule
